// File: rtl/core/thnl_pkg.sv
`default_nettype none
package thnl_pkg;

  localparam int NUM_STREAMS   = 8;
  localparam int DEPTH         = 16;
  localparam int PAYLOAD_WIDTH = 32;

  localparam int TIME_W  = 63;
  localparam int WIN_W   = 32;
  localparam int SID_W   = 3;
  localparam int LIM_W   = 5;
  localparam int MASK_W  = 8;
  localparam int CFG_W   = 40;
  localparam int SLOTS   = NUM_STREAMS * DEPTH;
  localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int SIDX_W  = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_QUERY  = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  localparam logic [1:0] MODE_EXACT   = 2'd0;
  localparam logic [1:0] MODE_WINDOW  = 2'd1;
  localparam logic [1:0] MODE_CLOSEST = 2'd2;
  localparam logic [1:0] MODE_UNSUPP  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ERR   = 2'd1;
  localparam logic [1:0] ST_INVAL = 2'd2;

  localparam logic CFG_ENABLE = 1'b0;
  localparam logic CFG_LIMITS = 1'b1;

  typedef struct packed {
    logic       load_req;
    logic       scan_start;
    logic       ins_write;
    logic       evict;
    logic       clear;
    logic       set_code;
    logic       set_best;
    logic       load_out;
    logic [1:0] code;
  } thnl_cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [1:0] query_mode;
    logic       configured;
    logic       live_any;
    logic       scan_done;
    logic       over_limit;
    logic       old_found;
  } thnl_stat_t;

endpackage
`default_nettype wire

// File: rtl/core/thnl_if.sv
`default_nettype none
interface thnl_req_if import thnl_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               req_type;
  logic [SID_W-1:0]         stream_id;
  logic [TIME_W-1:0]        key_time;
  logic [PAYLOAD_WIDTH-1:0] payload_in;
  logic [1:0]               query_mode;
  logic [WIN_W-1:0]         search_window;

  modport source (output valid, req_type, stream_id, key_time, payload_in, query_mode,
                  search_window, input ready);
  modport sink (input valid, req_type, stream_id, key_time, payload_in, query_mode,
                search_window, output ready);
endinterface

interface thnl_rsp_if import thnl_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic [TIME_W-1:0]        found_time;
  logic [PAYLOAD_WIDTH-1:0] payload_out;

  modport source (output valid, status, found_time, payload_out, input ready);
  modport sink (input valid, status, found_time, payload_out, output ready);
endinterface
`default_nettype wire

// File: rtl/core/thnl_datapath.sv
`default_nettype none
module thnl_datapath import thnl_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_we,
  input  wire logic                     cfg_index,
  input  wire logic [CFG_W-1:0]         cfg_data,
  input  wire logic [1:0]               req_type,
  input  wire logic [SID_W-1:0]         stream_id,
  input  wire logic [TIME_W-1:0]        key_time,
  input  wire logic [PAYLOAD_WIDTH-1:0] payload_in,
  input  wire logic [1:0]               query_mode,
  input  wire logic [WIN_W-1:0]         search_window,
  input  wire thnl_cmd_t                cmd,
  output thnl_stat_t                    stat,
  output logic [1:0]                    status,
  output logic [TIME_W-1:0]             found_time,
  output logic [PAYLOAD_WIDTH-1:0]      payload_out
);

  localparam logic [MASK_W-1:0] LIVE_MASK = MASK_W'((1 << NUM_STREAMS) - 1);

  logic [MASK_W-1:0] stream_enable_mask;
  logic [CFG_W-1:0]  stream_limits;

  logic [1:0]               rq_type;
  logic [SID_W-1:0]         rq_sid;
  logic [TIME_W-1:0]        rq_key;
  logic [PAYLOAD_WIDTH-1:0] rq_pay;
  logic [1:0]               rq_mode;
  logic [WIN_W-1:0]         rq_win;

  logic [TIME_W-1:0]        mem_t [SLOTS];
  logic [PAYLOAD_WIDTH-1:0] mem_p [SLOTS];
  logic [SLOTS-1:0]         valid;
  logic [CNT_W-1:0]         counts [NUM_STREAMS];

  logic [SIDX_W-1:0] rq_sidx;
  logic [SLOT_W-1:0] base;
  logic [LIM_W-1:0]  lim_field, lim_eff;
  logic [CNT_W-1:0]  cur_cnt;

  // scan pipeline
  logic [CNT_W-1:0]         iss;
  logic                     issuing;
  logic [SLOT_W-1:0]        rd_addr;
  logic                     v1, v2, v3;
  logic [IDX_W-1:0]         idx1, idx2, idx3;
  logic                     ok1, ok2, ok3;
  logic [TIME_W-1:0]        t1, t2, t3;
  logic [PAYLOAD_WIDTH-1:0] p1, p2, p3;
  logic [TIME_W:0]          diff2;
  logic [TIME_W-1:0]        d3;
  logic                     scan_done;

  logic                     best_ok, match_ok, free_ok, old_ok;
  logic [TIME_W-1:0]        best_d, best_t, old_t;
  logic [PAYLOAD_WIDTH-1:0] best_p;
  logic [IDX_W-1:0]         match_idx, free_idx, old_idx;
  logic                     qual, better;

  logic                     wr_t_en, wr_p_en;
  logic [SLOT_W-1:0]        wr_addr;
  logic                     ins_new;

  logic [1:0]               pend_status;
  logic [TIME_W-1:0]        pend_time;
  logic [PAYLOAD_WIDTH-1:0] pend_pay;

  function automatic logic [SLOT_W-1:0] slot_of(input logic [SLOT_W-1:0] b,
                                                 input logic [IDX_W-1:0] i);
    return b + SLOT_W'(i);
  endfunction

  assign rq_sidx   = rq_sid[SIDX_W-1:0];
  assign base      = SLOT_W'(rq_sidx) * SLOT_W'(DEPTH);
  assign lim_field = stream_limits[LIM_W*rq_sid +: LIM_W];
  assign lim_eff   = (lim_field > LIM_W'(DEPTH)) ? LIM_W'(DEPTH) : lim_field;
  assign cur_cnt   = counts[rq_sidx];

  assign stat.req_type   = rq_type;
  assign stat.query_mode = rq_mode;
  assign stat.configured = (32'(rq_sid) < NUM_STREAMS) && stream_enable_mask[rq_sid];
  assign stat.live_any   = |(stream_enable_mask & LIVE_MASK);
  assign stat.scan_done  = scan_done;
  assign stat.over_limit = LIM_W'(cur_cnt) > lim_eff;
  assign stat.old_found  = old_ok;

  assign issuing = iss < CNT_W'(DEPTH);
  assign rd_addr = slot_of(base, iss[IDX_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      stream_enable_mask <= '0;
      stream_limits      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENABLE: stream_enable_mask <= cfg_data[MASK_W-1:0];
        CFG_LIMITS: stream_limits      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      rq_type <= req_type;
      rq_sid  <= stream_id;
      rq_key  <= key_time;
      rq_pay  <= payload_in;
      rq_mode <= query_mode;
      rq_win  <= search_window;
    end
  end

  // write port selection for insert and its overwrite cases
  assign ins_new = !match_ok && free_ok;
  always_comb begin
    wr_t_en = 1'b0;
    wr_p_en = 1'b0;
    wr_addr = slot_of(base, old_idx);
    if (cmd.ins_write) begin
      if (match_ok) begin
        wr_p_en = 1'b1;
        wr_addr = slot_of(base, match_idx);
      end else if (free_ok) begin
        wr_t_en = 1'b1;
        wr_p_en = 1'b1;
        wr_addr = slot_of(base, free_idx);
      end else if (old_ok && rq_key > old_t) begin
        wr_t_en = 1'b1;
        wr_p_en = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_t_en) mem_t[wr_addr] <= rq_key;
    if (wr_p_en) mem_p[wr_addr] <= rq_pay;
    if (issuing) begin
      t1 <= mem_t[rd_addr];
      p1 <= mem_p[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      for (int s = 0; s < NUM_STREAMS; s++) counts[s] <= '0;
    end else if (cmd.clear) begin
      valid <= '0;
      for (int s = 0; s < NUM_STREAMS; s++) counts[s] <= '0;
    end else if (cmd.ins_write && ins_new) begin
      valid[slot_of(base, free_idx)] <= 1'b1;
      counts[rq_sidx] <= cur_cnt + CNT_W'(1);
    end else if (cmd.evict) begin
      valid[slot_of(base, old_idx)] <= 1'b0;
      counts[rq_sidx] <= cur_cnt - CNT_W'(1);
    end
  end

  // scan control: issue one slot a cycle, three stages behind
  always_ff @(posedge clk) begin
    if (rst) begin
      iss       <= CNT_W'(DEPTH);
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      scan_done <= 1'b0;
    end else begin
      if (cmd.scan_start) iss <= '0;
      else if (issuing) iss <= iss + CNT_W'(1);
      v1        <= issuing && !cmd.scan_start;
      v2        <= v1;
      v3        <= v2;
      scan_done <= v3 && (idx3 == IDX_W'(DEPTH - 1));
    end
  end

  always_ff @(posedge clk) begin
    idx1  <= iss[IDX_W-1:0];
    ok1   <= valid[rd_addr];
    idx2  <= idx1;
    ok2   <= ok1;
    t2    <= t1;
    p2    <= p1;
    diff2 <= {1'b0, t1} - {1'b0, rq_key};
    idx3  <= idx2;
    ok3   <= ok2;
    t3    <= t2;
    p3    <= p2;
    d3    <= diff2[TIME_W] ? TIME_W'(~diff2 + (TIME_W+1)'(1)) : diff2[TIME_W-1:0];
  end

  always_comb begin
    case (rq_mode)
      MODE_EXACT:  qual = ok3 && (d3 == '0);
      MODE_WINDOW: qual = ok3 && (d3 <= TIME_W'(rq_win));
      default:     qual = ok3;
    endcase
    better = !best_ok || (d3 < best_d) || ((d3 == best_d) && (t3 < best_t));
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      best_ok  <= 1'b0;
      match_ok <= 1'b0;
      free_ok  <= 1'b0;
      old_ok   <= 1'b0;
    end else if (v3) begin
      if (qual && better) begin
        best_ok <= 1'b1;
        best_d  <= d3;
        best_t  <= t3;
        best_p  <= p3;
      end
      if (ok3 && (t3 == rq_key) && !match_ok) begin
        match_ok  <= 1'b1;
        match_idx <= idx3;
      end
      if (!ok3 && !free_ok) begin
        free_ok  <= 1'b1;
        free_idx <= idx3;
      end
      if (ok3 && (!old_ok || (t3 < old_t))) begin
        old_ok  <= 1'b1;
        old_idx <= idx3;
        old_t   <= t3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_code) begin
      pend_status <= cmd.code;
      pend_time   <= '0;
      pend_pay    <= '0;
    end else if (cmd.set_best) begin
      pend_status <= best_ok ? ST_OK : ST_ERR;
      pend_time   <= best_ok ? best_t : '0;
      pend_pay    <= best_ok ? best_p : '0;
    end
    if (cmd.load_out) begin
      status      <= pend_status;
      found_time  <= pend_time;
      payload_out <= pend_pay;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/thnl_ctrl.sv
`default_nettype none
module thnl_ctrl import thnl_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire thnl_stat_t stat,
  output thnl_cmd_t       cmd
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DECIDE = 8'b0000_0010,
    S_SCAN   = 8'b0000_0100,
    S_WRITE  = 8'b0000_1000,
    S_EVCHK  = 8'b0001_0000,
    S_EVSCAN = 8'b0010_0000,
    S_EVICT  = 8'b0100_0000,
    S_RESP   = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_next   = S_RESP;
        cmd.set_code = 1'b1;
        case (stat.req_type)
          REQ_INSERT: begin
            if (!stat.live_any) begin
              cmd.code = ST_ERR;
            end else if (!stat.configured) begin
              cmd.code = ST_INVAL;
            end else begin
              cmd.set_code   = 1'b0;
              cmd.scan_start = 1'b1;
              state_next     = S_SCAN;
            end
          end
          REQ_QUERY: begin
            if (!stat.configured) begin
              cmd.code = ST_ERR;
            end else if (stat.query_mode == MODE_UNSUPP) begin
              cmd.code = ST_INVAL;
            end else begin
              cmd.set_code   = 1'b0;
              cmd.scan_start = 1'b1;
              state_next     = S_SCAN;
            end
          end
          REQ_CLEAR: begin
            cmd.clear = 1'b1;
            cmd.code  = ST_OK;
          end
          default: cmd.code = ST_INVAL;
        endcase
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          if (stat.req_type == REQ_INSERT) begin
            state_next = S_WRITE;
          end else begin
            cmd.set_best = 1'b1;
            state_next   = S_RESP;
          end
        end
      end
      S_WRITE: begin
        cmd.ins_write = 1'b1;
        state_next    = S_EVCHK;
      end
      S_EVCHK: begin
        if (stat.over_limit) begin
          cmd.scan_start = 1'b1;
          state_next     = S_EVSCAN;
        end else begin
          cmd.set_code = 1'b1;
          cmd.code     = ST_OK;
          state_next   = S_RESP;
        end
      end
      S_EVSCAN: begin
        if (stat.scan_done) state_next = S_EVICT;
      end
      S_EVICT: begin
        if (stat.old_found) begin
          cmd.evict  = 1'b1;
          state_next = S_EVCHK;
        end else begin
          cmd.set_code = 1'b1;
          cmd.code     = ST_OK;
          state_next   = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/timestamp_history_nearest_lookup.sv
// Channel  Dir  Handshake          Payload
// req      in   req.valid/ready    req_type, stream_id, key_time, payload_in,
//                                  query_mode, search_window
// rsp      out  rsp.valid/ready    status, found_time, payload_out
// cfg      in   cfg_we             cfg_index, cfg_data (no wait, no read-back)
//
// One request is in flight at a time. A query runs one scan of the stream's DEPTH
// slots through a single read port and compare pipeline. A plain insert adds a
// write-back and a limit check. Each eviction adds a further scan of the stream's
// slots. Clear, rejected and invalid requests skip the scan.
// Reset (synchronous, active high) clears valid bits and counts at once; no sweep.
// A new request is taken while the previous response still waits in the output
// register; a stalled response holds the next one in the response state.
`default_nettype none
module timestamp_history_nearest_lookup import thnl_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  thnl_req_if.sink              req,
  thnl_rsp_if.source            rsp
);

  thnl_cmd_t  cmd;
  thnl_stat_t stat;

  // sequencer: decode, scan, write-back, eviction loop, response
  thnl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // storage, scan pipeline and result registers
  thnl_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .req_type      (req.req_type),
    .stream_id     (req.stream_id),
    .key_time      (req.key_time),
    .payload_in    (req.payload_in),
    .query_mode    (req.query_mode),
    .search_window (req.search_window),
    .cmd           (cmd),
    .stat          (stat),
    .status        (rsp.status),
    .found_time    (rsp.found_time),
    .payload_out   (rsp.payload_out)
  );

endmodule
`default_nettype wire
